// File: design/sle_pkg.sv
`default_nettype none

package sle_pkg;

    // list store geometry
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // fixed field widths
    localparam int OP_W   = 4;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int ST_W   = 3;
    localparam int FIDX_W = 6;
    localparam int SIZE_W = 7;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 4'd0,
        OP_PUSH_FRONT = 4'd1,
        OP_POP_BACK   = 4'd2,
        OP_POP_FRONT  = 4'd3,
        OP_INSERT     = 4'd4,
        OP_ERASE      = 4'd5,
        OP_FIND       = 4'd6,
        OP_REMOVE     = 4'd7,
        OP_REMOVE_ALL = 4'd8,
        OP_FRONT      = 4'd9,
        OP_BACK       = 4'd10
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

endpackage

`default_nettype wire

// File: design/sle_ram.sv
`default_nettype none

module sle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/sequential_list_engine.sv
// channel   | valid     | stall     | payload
// ----------+-----------+-----------+--------------------------------------------------
// request   | req_valid | req_stall | opcode, position, value
// response  | rsp_valid | rsp_stall | status, found_index, read_value, list_size, is_empty
//
// one request at a time; a request streams each entry it moves or scans through the single
// store read port, one entry per cycle; push back skips the stream, pop back and rejected
// requests skip the run, and the next request can be taken in the cycle after its response
// is loaded.
// reset clears the count and the control state, not the store. a held response does not
// block the next request; a finished request waits while an earlier response is stalled.
`default_nettype none

module sequential_list_engine
    import sle_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output      logic              req_stall,
    input  wire logic [OP_W-1:0]   opcode,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [DATA_W-1:0] value,
    output      logic              rsp_valid,
    input  wire logic              rsp_stall,
    output      logic [ST_W-1:0]   status,
    output      logic [FIDX_W-1:0] found_index,
    output      logic [DATA_W-1:0] read_value,
    output      logic [SIZE_W-1:0] list_size,
    output      logic              is_empty
);

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t            state_reg,    state_next;
    opcode_t           op_reg,       op_next;
    logic [CNT_W-1:0]  cnt_reg,      cnt_next;
    logic [CNT_W-1:0]  pos_reg,      pos_next;
    logic [CNT_W-1:0]  rd_ptr_reg,   rd_ptr_next;
    logic [CNT_W-1:0]  rem_reg,      rem_next;
    logic [CNT_W-1:0]  ret_addr_reg, ret_addr_next;
    logic [CNT_W-1:0]  gone_reg,     gone_next;
    logic              ret_vld_reg,  ret_vld_next;
    logic              hit_reg,      hit_next;
    logic [FIDX_W-1:0] hit_idx_reg,  hit_idx_next;
    logic [DATA_W-1:0] val_reg,      val_next;
    logic [DATA_W-1:0] rval_reg,     rval_next;
    status_t           st_reg,       st_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [ST_W-1:0]   rsp_status_reg;
    logic [FIDX_W-1:0] rsp_fidx_reg;
    logic [DATA_W-1:0] rsp_rval_reg;
    logic [SIZE_W-1:0] rsp_size_reg;
    logic              rsp_empty_reg;
    logic              load_rsp;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              is_open;
    logic              is_close;
    logic              is_peek;
    logic              is_find;
    logic              match;
    logic              first_hit;
    logic              drop;
    logic              full;
    logic              empty;
    logic [CNT_W-1:0]  pos_in;
    logic [CMP_W-1:0]  pos_cmp;
    logic [CMP_W-1:0]  cnt_cmp;
    logic [CNT_W-1:0]  wa_up;
    logic [CNT_W-1:0]  wa_down;

    // list store
    sle_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // operation classes of the request in flight
    assign is_open  = (op_reg == OP_PUSH_BACK) || (op_reg == OP_PUSH_FRONT)
                   || (op_reg == OP_INSERT);
    assign is_close = (op_reg == OP_POP_FRONT) || (op_reg == OP_ERASE);
    assign is_peek  = (op_reg == OP_FRONT) || (op_reg == OP_BACK);
    assign is_find  = (op_reg == OP_FIND);

    // compare of the returned entry and drop decision for compaction
    assign match     = (ram_rdata == val_reg);
    assign first_hit = match && !hit_reg;
    always_comb
    begin
        if (is_close)
        begin
            drop = (ret_addr_reg == pos_reg);
        end
        else if (op_reg == OP_REMOVE)
        begin
            drop = first_hit;
        end
        else if (op_reg == OP_REMOVE_ALL)
        begin
            drop = match;
        end
        else
        begin
            drop = 1'b0;
        end
    end

    assign wa_up   = ret_addr_reg + CNT_W'(1);
    assign wa_down = ret_addr_reg - gone_reg;

    // request checks
    assign full    = (cnt_reg >= DEPTH_CNT);
    assign empty   = (cnt_reg == '0);
    assign pos_in  = CNT_W'(position);
    assign pos_cmp = CMP_W'(position);
    assign cnt_cmp = CMP_W'(cnt_reg);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        rd_ptr_next   = rd_ptr_reg;
        rem_next      = rem_reg;
        ret_addr_next = ret_addr_reg;
        gone_next     = gone_reg;
        ret_vld_next  = ret_vld_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        val_next      = val_reg;
        rval_next     = rval_reg;
        st_next       = st_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = val_reg;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        load_rsp      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next      = opcode_t'(opcode);
                    val_next     = value;
                    pos_next     = pos_in;
                    st_next      = ST_OK;
                    rval_next    = '0;
                    hit_next     = 1'b0;
                    hit_idx_next = '0;
                    gone_next    = '0;
                    ret_vld_next = 1'b0;
                    rd_ptr_next  = '0;
                    rem_next     = cnt_reg;
                    state_next   = S_RUN;
                    case (opcode_t'(opcode))
                        OP_PUSH_BACK:
                        begin
                            pos_next    = cnt_reg;
                            rem_next    = '0;
                            rd_ptr_next = cnt_reg - CNT_W'(1);
                            if (full)
                            begin
                                st_next    = ST_FULL;
                                state_next = S_DONE;
                            end
                        end
                        OP_PUSH_FRONT:
                        begin
                            pos_next    = '0;
                            rd_ptr_next = cnt_reg - CNT_W'(1);
                            if (full)
                            begin
                                st_next    = ST_FULL;
                                state_next = S_DONE;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            state_next = S_DONE;
                            if (empty)
                            begin
                                st_next = ST_EMPTY;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            pos_next = '0;
                            if (empty)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_DONE;
                            end
                        end
                        OP_INSERT:
                        begin
                            rd_ptr_next = cnt_reg - CNT_W'(1);
                            rem_next    = cnt_reg - pos_in;
                            if (pos_cmp > cnt_cmp)
                            begin
                                st_next    = ST_BAD_POS;
                                state_next = S_DONE;
                            end
                            else if (full)
                            begin
                                st_next    = ST_FULL;
                                state_next = S_DONE;
                            end
                        end
                        OP_ERASE:
                        begin
                            rd_ptr_next = pos_in;
                            rem_next    = cnt_reg - pos_in;
                            if (pos_cmp >= cnt_cmp)
                            begin
                                st_next    = ST_BAD_POS;
                                state_next = S_DONE;
                            end
                        end
                        OP_FIND, OP_REMOVE, OP_REMOVE_ALL:
                        begin
                            rem_next = cnt_reg;
                        end
                        OP_FRONT:
                        begin
                            rem_next = CNT_W'(1);
                            if (empty)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_DONE;
                            end
                        end
                        OP_BACK:
                        begin
                            rem_next    = CNT_W'(1);
                            rd_ptr_next = cnt_reg - CNT_W'(1);
                            if (empty)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_RUN:
            begin
                // issue the next read
                if (rem_reg != '0)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = rd_ptr_reg[ADDR_W-1:0];
                    ret_vld_next  = 1'b1;
                    ret_addr_next = rd_ptr_reg;
                    rem_next      = rem_reg - CNT_W'(1);
                    rd_ptr_next   = is_open ? (rd_ptr_reg - CNT_W'(1))
                                            : (rd_ptr_reg + CNT_W'(1));
                end
                else
                begin
                    ret_vld_next = 1'b0;
                end

                // handle the entry read in the previous cycle
                if (ret_vld_reg)
                begin
                    if (is_peek)
                    begin
                        rval_next = ram_rdata;
                    end
                    else if (is_open)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = wa_up[ADDR_W-1:0];
                        ram_wdata = ram_rdata;
                    end
                    else
                    begin
                        if (first_hit)
                        begin
                            hit_next     = 1'b1;
                            hit_idx_next = FIDX_W'(ret_addr_reg);
                        end
                        if (drop)
                        begin
                            gone_next = gone_reg + CNT_W'(1);
                        end
                        else if (!is_find)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = wa_down[ADDR_W-1:0];
                            ram_wdata = ram_rdata;
                        end
                    end
                end

                // stream drained: finish the request
                if ((rem_reg == '0) && !ret_vld_reg)
                begin
                    state_next = S_DONE;
                    if (is_open)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = pos_reg[ADDR_W-1:0];
                        ram_wdata = val_reg;
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                    else if (!is_peek)
                    begin
                        cnt_next = cnt_reg - gone_reg;
                    end
                    if ((is_find || (op_reg == OP_REMOVE)) && !hit_reg)
                    begin
                        st_next = ST_NOT_FOUND;
                    end
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    load_rsp   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // response handshake
    assign rsp_valid_next = (rsp_valid_reg && rsp_stall) || load_rsp;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            ret_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            ret_vld_reg   <= ret_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        rd_ptr_reg   <= rd_ptr_next;
        ret_addr_reg <= ret_addr_next;
        gone_reg     <= gone_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        val_reg      <= val_next;
        rval_reg     <= rval_next;
        st_reg       <= st_next;
        if (load_rsp)
        begin
            rsp_status_reg <= st_reg;
            rsp_fidx_reg   <= is_find ? hit_idx_reg : '0;
            rsp_rval_reg   <= rval_reg;
            rsp_size_reg   <= SIZE_W'(cnt_reg);
            rsp_empty_reg  <= (cnt_reg == '0);
        end
    end

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign found_index = rsp_fidx_reg;
    assign read_value  = rsp_rval_reg;
    assign list_size   = rsp_size_reg;
    assign is_empty    = rsp_empty_reg;

endmodule

`default_nettype wire

// File: design/sle_checker.sv
`default_nettype none

module sle_checker
    import sle_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_stall,
    input wire logic              rsp_valid,
    input wire logic              rsp_stall,
    input wire logic [ST_W-1:0]   status,
    input wire logic [FIDX_W-1:0] found_index,
    input wire logic [SIZE_W-1:0] list_size,
    input wire logic              is_empty
);

    // empty flag agrees with the reported size
    a_empty_size: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (is_empty == (list_size == '0)))
        else $error("is_empty disagrees with list_size");

    // size never exceeds the store
    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (list_size <= SIZE_W'(DEPTH)))
        else $error("list_size above store depth");

    // a request occupies the engine for at least the next cycle
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted back to back");

    // a nonzero match index only comes with a good status
    a_fidx_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (found_index != '0)) |-> (status == ST_OK))
        else $error("found_index set on a failed request");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status) && $stable(list_size)))
        else $error("stalled response changed");

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .found_index (found_index),
    .list_size   (list_size),
    .is_empty    (is_empty)
);

`default_nettype wire

// File: tb/sequential_list_engine_tb.sv
`timescale 1ns / 1ps

module sequential_list_engine_tb;

    import sle_pkg::*;

    localparam logic [OP_W-1:0]   OP_SPARE_FIRST = OP_BACK + 1'b1;
    localparam logic [OP_W-1:0]   OP_SPARE_LAST  = '1;
    localparam logic [DATA_W-1:0] WORD_MIN       = 32'h8000_0000;
    localparam logic [DATA_W-1:0] WORD_MAX       = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] WORD_ONES      = '1;
    localparam int                POOL_SIZE      = 8;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [FIDX_W-1:0] found_index;
        logic [DATA_W-1:0] read_value;
        logic [SIZE_W-1:0] list_size;
        logic              is_empty;
    } answer_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    logic [OP_W-1:0]   opcode    = '0;
    logic [POS_W-1:0]  position  = '0;
    logic [DATA_W-1:0] value     = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    logic [ST_W-1:0]   status;
    logic [FIDX_W-1:0] found_index;
    logic [DATA_W-1:0] read_value;
    logic [SIZE_W-1:0] list_size;
    logic              is_empty;

    // shadow copy of the list, advanced at each accepted request
    logic [DATA_W-1:0] shadow_list [DEPTH];
    int                shadow_count = 0;
    answer_t           answer_q [$];

    logic [DATA_W-1:0] value_pool [POOL_SIZE];
    bit                req_gaps_on   = 1'b1;
    bit                rsp_gaps_on   = 1'b1;
    int                rsp_hold_left = 0;
    int                rsp_burst_left = 0;
    int                error_count   = 0;

    sequential_list_engine u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .opcode      (opcode),
        .position    (position),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .found_index (found_index),
        .read_value  (read_value),
        .list_size   (list_size),
        .is_empty    (is_empty)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow list helpers
    function automatic int shadow_find(logic [DATA_W-1:0] v);
        int i;
        for (i = 0; i < shadow_count; i++)
        begin
            if (shadow_list[i] == v)
                return i;
        end
        return shadow_count;
    endfunction

    function automatic void shadow_open(int pos, logic [DATA_W-1:0] v);
        int i;
        for (i = shadow_count; i > pos; i--)
            shadow_list[i] = shadow_list[i - 1];
        shadow_list[pos] = v;
        shadow_count++;
    endfunction

    function automatic void shadow_close(int pos);
        int i;
        for (i = pos; i + 1 < shadow_count; i++)
            shadow_list[i] = shadow_list[i + 1];
        shadow_count--;
    endfunction

    // applies one request to the shadow list and returns the expected response
    function automatic answer_t apply_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                              logic [DATA_W-1:0] val);
        answer_t ans;
        int      k;
        int      gone;
        int      i;
        ans        = '0;
        ans.status = ST_OK;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (shadow_count >= DEPTH)
                    ans.status = ST_FULL;
                else
                    shadow_open((op == OP_PUSH_BACK) ? shadow_count : 0, val);
            end
            OP_POP_BACK:
            begin
                if (shadow_count == 0)
                    ans.status = ST_EMPTY;
                else
                    shadow_count--;
            end
            OP_POP_FRONT:
            begin
                if (shadow_count == 0)
                    ans.status = ST_EMPTY;
                else
                    shadow_close(0);
            end
            OP_INSERT:
            begin
                if (int'(pos) > shadow_count)
                    ans.status = ST_BAD_POS;
                else if (shadow_count >= DEPTH)
                    ans.status = ST_FULL;
                else
                    shadow_open(int'(pos), val);
            end
            OP_ERASE:
            begin
                if (int'(pos) >= shadow_count)
                    ans.status = ST_BAD_POS;
                else
                    shadow_close(int'(pos));
            end
            OP_FIND:
            begin
                k = shadow_find(val);
                if (k >= shadow_count)
                    ans.status = ST_NOT_FOUND;
                else
                    ans.found_index = FIDX_W'(k);
            end
            OP_REMOVE:
            begin
                k = shadow_find(val);
                if (k >= shadow_count)
                    ans.status = ST_NOT_FOUND;
                else
                    shadow_close(k);
            end
            OP_REMOVE_ALL:
            begin
                // compact the survivors in order
                gone = 0;
                for (i = 0; i < shadow_count; i++)
                begin
                    if (shadow_list[i] == val)
                        gone++;
                    else
                        shadow_list[i - gone] = shadow_list[i];
                end
                shadow_count -= gone;
            end
            OP_FRONT:
            begin
                if (shadow_count == 0)
                    ans.status = ST_EMPTY;
                else
                    ans.read_value = shadow_list[0];
            end
            OP_BACK:
            begin
                if (shadow_count == 0)
                    ans.status = ST_EMPTY;
                else
                    ans.read_value = shadow_list[shadow_count - 1];
            end
            default:
            begin
            end
        endcase
        ans.list_size = SIZE_W'(shadow_count);
        ans.is_empty  = (shadow_count == 0);
        return ans;
    endfunction

    // drive one request and hold it until the block takes it
    task automatic send_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic [DATA_W-1:0] val);
        if (req_gaps_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req_valid <= 1'b1;
        opcode    <= op;
        position  <= pos;
        value     <= val;
        do
            @(posedge clk);
        while (req_stall);
        answer_q.push_back(apply_list_op(op, pos, val));
    endtask

    task automatic wait_for_answers();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (answer_q.size() != 0);
    endtask

    // mostly values from a small pool so that searches hit
    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 7) == 0)
            return POS_W'($urandom_range(0, (1 << POS_W) - 1));
        return POS_W'($urandom_range(0, shadow_count + 1));
    endfunction

    task automatic send_random_item(int grow_pct);
        logic [OP_W-1:0] op;
        int              r;
        r = $urandom_range(0, 99);
        if (r < grow_pct)
        begin
            case ($urandom_range(0, 2))
                0:       op = OP_PUSH_BACK;
                1:       op = OP_PUSH_FRONT;
                default: op = OP_INSERT;
            endcase
        end
        else if (r < 86)
        begin
            case ($urandom_range(0, 4))
                0:       op = OP_POP_BACK;
                1:       op = OP_POP_FRONT;
                2:       op = OP_ERASE;
                3:       op = OP_REMOVE;
                default: op = OP_REMOVE_ALL;
            endcase
        end
        else if (r < 97)
        begin
            case ($urandom_range(0, 2))
                0:       op = OP_FIND;
                1:       op = OP_FRONT;
                default: op = OP_BACK;
            endcase
        end
        else
            op = OP_W'($urandom_range(0, (1 << OP_W) - 1));
        send_request(op, pick_position(), pick_value());
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] exp, logic [DATA_W-1:0] act);
        if (act !== exp)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
        end
    endtask

    task automatic check_response();
        answer_t exp;
        if (answer_q.size() == 0)
        begin
            error_count++;
            $display("%0t: response with no request pending, expected none, actual status %0h",
                     $time, status);
        end
        else
        begin
            exp = answer_q.pop_front();
            check_field("status", DATA_W'(exp.status), DATA_W'(status));
            check_field("found_index", DATA_W'(exp.found_index), DATA_W'(found_index));
            check_field("read_value", exp.read_value, read_value);
            check_field("list_size", DATA_W'(exp.list_size), DATA_W'(list_size));
            check_field("is_empty", DATA_W'(exp.is_empty), DATA_W'(is_empty));
        end
    endtask

    // response side: check accepted responses and drive the stall
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                check_response();
            if (rsp_hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                rsp_hold_left--;
            end
            else if (rsp_burst_left > 0)
            begin
                rsp_stall <= 1'b1;
                rsp_burst_left--;
            end
            else if (rsp_gaps_on && $urandom_range(0, 5) == 0)
            begin
                rsp_stall      <= 1'b1;
                rsp_burst_left = $urandom_range(1, 13) - 1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // every read or removal on an empty list, an insert past the end, plus unused opcodes
    task automatic test_empty_list();
        send_request(OP_POP_BACK, '0, '0);
        send_request(OP_POP_FRONT, '0, '0);
        send_request(OP_FRONT, '0, '0);
        send_request(OP_BACK, '0, '0);
        send_request(OP_ERASE, '0, '0);
        send_request(OP_INSERT, POS_W'(1), WORD_MAX);
        send_request(OP_FIND, '0, '0);
        send_request(OP_REMOVE, '0, WORD_ONES);
        send_request(OP_REMOVE_ALL, '0, '0);
        send_request(OP_SPARE_FIRST, '1, WORD_ONES);
        send_request(OP_SPARE_LAST, '1, WORD_MIN);
    endtask

    // extreme values, positions at both ends of a short list
    task automatic test_small_list_edges();
        send_request(OP_PUSH_BACK, '0, WORD_MAX);
        send_request(OP_PUSH_FRONT, '0, WORD_MIN);
        send_request(OP_INSERT, POS_W'(1), '0);
        send_request(OP_INSERT, POS_W'(3), WORD_ONES);
        send_request(OP_INSERT, POS_W'(5), WORD_MAX);
        send_request(OP_INSERT, '1, WORD_MAX);
        send_request(OP_FRONT, '0, '0);
        send_request(OP_BACK, '0, '0);
        send_request(OP_FIND, '0, WORD_MAX);
        send_request(OP_ERASE, POS_W'(4), '0);
        send_request(OP_ERASE, '1, '0);
        send_request(OP_ERASE, POS_W'(1), '0);
        send_request(OP_REMOVE, '0, WORD_ONES);
        send_request(OP_PUSH_BACK, '0, WORD_MAX);
        send_request(OP_REMOVE_ALL, '0, WORD_MAX);
        send_request(OP_POP_FRONT, '0, '0);
    endtask

    // grow to capacity, hit the full cases, then thin out with remove-all of each pool value
    task automatic test_fill_to_full();
        logic [DATA_W-1:0] marker;
        int                i;
        while (shadow_count < DEPTH - 1)
        begin
            case ($urandom_range(0, 2))
                0:       send_request(OP_PUSH_BACK, '0, pick_value());
                1:       send_request(OP_PUSH_FRONT, '0, pick_value());
                default: send_request(OP_INSERT, POS_W'($urandom_range(0, shadow_count)),
                                      pick_value());
            endcase
        end
        marker = $urandom;
        send_request(OP_PUSH_BACK, '0, marker);
        send_request(OP_PUSH_BACK, '0, WORD_ONES);
        send_request(OP_PUSH_FRONT, '0, WORD_MIN);
        send_request(OP_INSERT, POS_W'(DEPTH), '0);
        send_request(OP_INSERT, POS_W'(DEPTH + 1), '0);
        send_request(OP_FIND, '0, marker);
        send_request(OP_BACK, '0, '0);
        send_request(OP_FRONT, '0, '0);
        send_request(OP_ERASE, POS_W'(DEPTH), '0);
        send_request(OP_ERASE, POS_W'(DEPTH - 1), '0);
        send_request(OP_POP_FRONT, '0, '0);
        for (i = 0; i < POOL_SIZE; i++)
            send_request(OP_REMOVE_ALL, '0, value_pool[i]);
    endtask

    task automatic test_random_mix(int n, int grow_pct);
        repeat (n) send_random_item(grow_pct);
    endtask

    // long response hold-off so the block backs up and stalls requests
    task automatic test_response_backlog();
        req_gaps_on   = 1'b0;
        rsp_hold_left = 400;
        repeat (40) send_random_item(55);
        req_gaps_on   = 1'b1;
    endtask

    // sender goes quiet until every response is back
    task automatic test_sender_pause();
        repeat (15) send_random_item(50);
        wait_for_answers();
        repeat (15) send_random_item(50);
        wait_for_answers();
    endtask

    initial
    begin
        int i;
        value_pool[0] = '0;
        value_pool[1] = WORD_ONES;
        value_pool[2] = WORD_MIN;
        value_pool[3] = WORD_MAX;
        for (i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_small_list_edges();
        test_fill_to_full();
        test_random_mix(250, 60);
        test_random_mix(250, 25);
        req_gaps_on = 1'b0;
        test_random_mix(250, 65);
        req_gaps_on = 1'b1;
        rsp_gaps_on = 1'b0;
        test_random_mix(250, 30);
        rsp_gaps_on = 1'b1;
        test_random_mix(250, 55);
        test_response_backlog();
        test_sender_pause();

        // closing stretch at full rate on both sides
        req_gaps_on = 1'b0;
        rsp_gaps_on = 1'b0;
        test_random_mix(440, 50);

        req_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
